// ----- rtl/core/hmc_pkg.sv -----
// hmc_pkg: shared types and constants of the histogram mean / confidence block.
// Holds controller states, the command and status structs and field widths.
// No dependencies.
package hmc_pkg;

   localparam int VALUE_W     = 16;
   localparam int COUNT_W     = 20;
   localparam int RUN_W       = 20;
   localparam int CF_W        = 16;
   localparam int SUM_W       = 64;
   localparam int MEAN_W      = 32;
   localparam int BOUND_W     = 33;
   localparam int SQ_W        = 48;
   localparam int PROD_W      = 44;
   localparam int DVD_W       = 80;
   localparam int DVS_W       = 40;
   localparam int ROOT_W      = 32;
   localparam int SREM_W      = 36;
   localparam int RSP_DATA_W  = 136;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;
   localparam logic [RUN_W-1:0]   RUN_RESET = 20'd1;
   localparam logic [CF_W-1:0]    CF_RESET  = 16'd8028;

   localparam logic ACT_RECORD = 1'b0;
   localparam logic ACT_REPORT = 1'b1;

   // register index taken from paddr[2]
   localparam logic REG_RUN_COUNT = 1'b0;
   localparam logic REG_CONF      = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REC_LOOK,
      ST_REC_CMP,
      ST_SUM_LOOK,
      ST_SUM_ACC,
      ST_DIV_MEAN,
      ST_VAR_LOOK,
      ST_VAR_SQ,
      ST_VAR_MLO,
      ST_VAR_MHI,
      ST_VAR_ADD,
      ST_DIV_VAR,
      ST_SQRT,
      ST_HALF,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic idx_clr;
      logic idx_inc;
      logic rd_en;
      logic cnt_upd;
      logic append;
      logic set_ovf;
      logic sum_acc;
      logic div_mean;
      logic div_var;
      logic div_step;
      logic mean_load;
      logic sq_calc;
      logic mul_lo;
      logic mul_hi;
      logic var_add;
      logic sqrt_start;
      logic sqrt_step;
      logic half_calc;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic at_end;
      logic full;
      logic div_done;
      logic sqrt_done;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/core/histogram_mean_confidence.sv -----
// Histogram of 16-bit sample values with weighted mean and confidence interval.
// Input stream (req_*): one beat per item. req_tuser is the action (0 record,
// 1 report); req_tdata[15:0] is the sample value, ignored on a report.
// A record scans the table with a lookup and a compare state per stored entry,
// then bumps the matching count or appends; a new value hitting a full table
// is dropped and sets the sticky overflow flag. A record yields no result beat.
// A report produces one result beat (rsp_*) after a pass over the stored
// entries for the weighted sum, the shared divider for the mean, a second pass
// (square, weighted multiply and add per entry) for the variance, the divider
// again and the square root. Only one item is worked on at a time; req_tready
// is high only while the sequencer is idle. The result sits in an output
// register; if the receiver stalls, a report waits for it before loading, while
// a finished beat stays on rsp_tdata. Reset (synchronous) empties the table,
// clears overflow, run_count=1 and confidence_factor=1.96 (Q4.12).
// The user writes registers via the csr_* port at byte addresses 0 (run_count)
// and 4 (confidence_factor) only while idle; the block does not enforce it.
module histogram_mean_confidence #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic                                  req_tuser,  // [0] action
   input  logic [15:0]                           req_tdata,  // [15:0] sample_value
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] mean_value, [63:32] half_width, [96:64] lower_bound,
   // [129:97] upper_bound, [130] table_overflow, [135:131] zero
   output logic [hmc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [hmc_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [hmc_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [hmc_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   logic [hmc_pkg::RUN_W-1:0] run_count_ff;
   logic [hmc_pkg::CF_W-1:0]  conf_ff;
   logic                      csr_wr;
   hmc_pkg::cmd_type          cmd;
   hmc_pkg::status_type       status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff <= hmc_pkg::RUN_RESET;
         conf_ff      <= hmc_pkg::CF_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == hmc_pkg::REG_RUN_COUNT) begin
            run_count_ff <= csr_pwdata[hmc_pkg::RUN_W-1:0];
         end else begin
            conf_ff <= csr_pwdata[hmc_pkg::CF_W-1:0];
         end
      end
   end

   always_comb begin
      case (csr_paddr[2])
         hmc_pkg::REG_RUN_COUNT: csr_prdata = hmc_pkg::CSR_DATA_W'(run_count_ff);
         hmc_pkg::REG_CONF:      csr_prdata = hmc_pkg::CSR_DATA_W'(conf_ff);
         default:                csr_prdata = '0;
      endcase
   end

   hmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hmc_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .sample_in   (req_tdata),
      .run_count   (run_count_ff),
      .conf_factor (conf_ff),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ----- rtl/core/hmc_ctrl.sv -----
// hmc_ctrl: sequencer for record scans and the two-pass report.
// Drives hmc_pkg::cmd_type toward the datapath, reads hmc_pkg::status_type.
// Depends on hmc_pkg.
module hmc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_action,
   output logic                 req_tready,
   input  hmc_pkg::status_type  status,
   output hmc_pkg::cmd_type     cmd
);

   hmc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hmc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hmc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_action == hmc_pkg::ACT_REPORT) ? hmc_pkg::ST_SUM_LOOK
                                                              : hmc_pkg::ST_REC_LOOK;
            end
         end
         hmc_pkg::ST_REC_LOOK: begin
            state_in = status.at_end ? hmc_pkg::ST_IDLE : hmc_pkg::ST_REC_CMP;
         end
         hmc_pkg::ST_REC_CMP: begin
            state_in = status.hit ? hmc_pkg::ST_IDLE : hmc_pkg::ST_REC_LOOK;
         end
         hmc_pkg::ST_SUM_LOOK: begin
            state_in = status.at_end ? hmc_pkg::ST_DIV_MEAN : hmc_pkg::ST_SUM_ACC;
         end
         hmc_pkg::ST_SUM_ACC:  state_in = hmc_pkg::ST_SUM_LOOK;
         hmc_pkg::ST_DIV_MEAN: begin
            if (status.div_done) state_in = hmc_pkg::ST_VAR_LOOK;
         end
         hmc_pkg::ST_VAR_LOOK: begin
            state_in = status.at_end ? hmc_pkg::ST_DIV_VAR : hmc_pkg::ST_VAR_SQ;
         end
         hmc_pkg::ST_VAR_SQ:   state_in = hmc_pkg::ST_VAR_MLO;
         hmc_pkg::ST_VAR_MLO:  state_in = hmc_pkg::ST_VAR_MHI;
         hmc_pkg::ST_VAR_MHI:  state_in = hmc_pkg::ST_VAR_ADD;
         hmc_pkg::ST_VAR_ADD:  state_in = hmc_pkg::ST_VAR_LOOK;
         hmc_pkg::ST_DIV_VAR: begin
            if (status.div_done) state_in = hmc_pkg::ST_SQRT;
         end
         hmc_pkg::ST_SQRT: begin
            if (status.sqrt_done) state_in = hmc_pkg::ST_HALF;
         end
         hmc_pkg::ST_HALF:     state_in = hmc_pkg::ST_OUT;
         hmc_pkg::ST_OUT: begin
            if (status.out_free) state_in = hmc_pkg::ST_IDLE;
         end
         default:              state_in = hmc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         hmc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               cmd.idx_clr = 1'b1;
            end
         end
         hmc_pkg::ST_REC_LOOK: begin
            if (status.at_end) begin
               if (status.full) cmd.set_ovf = 1'b1;
               else             cmd.append  = 1'b1;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         hmc_pkg::ST_REC_CMP: begin
            if (status.hit) cmd.cnt_upd = 1'b1;
            else            cmd.idx_inc = 1'b1;
         end
         hmc_pkg::ST_SUM_LOOK: begin
            if (status.at_end) cmd.div_mean = 1'b1;
            else               cmd.rd_en    = 1'b1;
         end
         hmc_pkg::ST_SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         hmc_pkg::ST_DIV_MEAN: begin
            if (status.div_done) begin
               cmd.mean_load = 1'b1;
               cmd.idx_clr   = 1'b1;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         hmc_pkg::ST_VAR_LOOK: begin
            if (status.at_end) cmd.div_var = 1'b1;
            else               cmd.rd_en   = 1'b1;
         end
         hmc_pkg::ST_VAR_SQ:  cmd.sq_calc = 1'b1;
         hmc_pkg::ST_VAR_MLO: cmd.mul_lo  = 1'b1;
         hmc_pkg::ST_VAR_MHI: cmd.mul_hi  = 1'b1;
         hmc_pkg::ST_VAR_ADD: begin
            cmd.var_add = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         hmc_pkg::ST_DIV_VAR: begin
            if (status.div_done) cmd.sqrt_start = 1'b1;
            else                 cmd.div_step   = 1'b1;
         end
         hmc_pkg::ST_SQRT: begin
            if (status.sqrt_done) cmd.half_calc = 1'b1;
            else                  cmd.sqrt_step = 1'b1;
         end
         hmc_pkg::ST_HALF: begin
         end
         hmc_pkg::ST_OUT: begin
            if (status.out_free) cmd.out_load = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/core/hmc_datapath.sv -----
// hmc_datapath: value/count tables, accumulators, shared restoring divider,
// bit-pair square root and the result register.
// Depends on hmc_pkg; commanded by hmc_ctrl.
module hmc_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hmc_pkg::cmd_type                  cmd,
   output hmc_pkg::status_type               status,
   input  logic [hmc_pkg::VALUE_W-1:0]       sample_in,
   input  logic [hmc_pkg::RUN_W-1:0]         run_count,
   input  logic [hmc_pkg::CF_W-1:0]          conf_factor,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [hmc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int DCNT_W = $clog2(hmc_pkg::DVD_W + 1);
   localparam int SCNT_W = $clog2(hmc_pkg::ROOT_W + 1);

   logic [hmc_pkg::VALUE_W-1:0] value_mem [TABLE_DEPTH];
   logic [hmc_pkg::COUNT_W-1:0] count_mem [TABLE_DEPTH];

   logic [hmc_pkg::VALUE_W-1:0] sample_ff;
   logic [CNT_W-1:0]            idx_ff, used_ff;
   logic                        ovf_ff;
   logic [hmc_pkg::VALUE_W-1:0] rd_value_ff;
   logic [hmc_pkg::COUNT_W-1:0] rd_count_ff;
   logic [hmc_pkg::SUM_W-1:0]   sum_ff, var_ff;
   logic [hmc_pkg::MEAN_W-1:0]  mean_ff, half_ff;
   logic [hmc_pkg::SQ_W-1:0]    sq_ff;
   logic [hmc_pkg::PROD_W-1:0]  plo_ff, phi_ff;
   logic [hmc_pkg::DVS_W:0]     rem_ff;
   logic [hmc_pkg::DVD_W-1:0]   quo_ff;
   logic [hmc_pkg::DVS_W-1:0]   dvs_ff;
   logic [DCNT_W-1:0]           dcnt_ff;
   logic [hmc_pkg::SUM_W-1:0]   x_ff;
   logic [hmc_pkg::SREM_W-1:0]  srem_ff;
   logic [hmc_pkg::ROOT_W-1:0]  root_ff;
   logic [SCNT_W-1:0]           scnt_ff;
   logic                        out_valid_ff;
   logic [hmc_pkg::RSP_DATA_W-1:0] out_data_ff;

   logic [hmc_pkg::RUN_W-1:0]   n_eff;
   logic [hmc_pkg::DVS_W-1:0]   n_sq;
   logic [hmc_pkg::COUNT_W-1:0] cnt_inc;
   logic [35:0]                 vc_prod;
   logic [hmc_pkg::MEAN_W-1:0]  v16, diff;
   logic [23:0]                 dev;
   logic [67:0]                 term;
   logic [hmc_pkg::SUM_W:0]     var_sum;
   logic [hmc_pkg::DVS_W:0]     rem_sh, rem_sub;
   logic                        div_ge;
   logic [hmc_pkg::SREM_W-1:0]  srem_sh, trial;
   logic                        sq_ge;
   logic [47:0]                 half_prod;
   logic [hmc_pkg::BOUND_W-1:0] lo_bound, up_bound;

   assign n_eff   = (run_count == '0) ? hmc_pkg::RUN_W'(1) : run_count;
   assign n_sq    = n_eff * n_eff;
   assign cnt_inc = (rd_count_ff == hmc_pkg::COUNT_MAX) ? rd_count_ff : rd_count_ff + 1'b1;
   assign vc_prod = rd_value_ff * rd_count_ff;
   assign v16     = {rd_value_ff, 16'h0000};
   assign diff    = (mean_ff >= v16) ? mean_ff - v16 : v16 - mean_ff;
   assign dev     = diff[31:8];
   assign term    = {phi_ff, 24'h000000} + {24'h000000, plo_ff};
   assign var_sum = {1'b0, var_ff} + {1'b0, term[63:0]};

   assign rem_sh  = {rem_ff[hmc_pkg::DVS_W-1:0], quo_ff[hmc_pkg::DVD_W-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign div_ge  = (rem_sh >= {1'b0, dvs_ff});

   assign srem_sh = {srem_ff[hmc_pkg::SREM_W-3:0], x_ff[hmc_pkg::SUM_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign sq_ge   = (srem_sh >= trial);

   assign half_prod = conf_factor * root_ff;
   assign lo_bound  = {1'b0, mean_ff} - {1'b0, half_ff};
   assign up_bound  = {1'b0, mean_ff} + {1'b0, half_ff};

   assign status.hit       = (rd_value_ff == sample_ff);
   assign status.at_end    = (idx_ff == used_ff);
   assign status.full      = (used_ff == CNT_W'(TABLE_DEPTH));
   assign status.div_done  = (dcnt_ff == '0);
   assign status.sqrt_done = (scnt_ff == '0);
   assign status.out_free  = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // table ports: one write, one registered read at the scan index
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_value_ff <= value_mem[idx_ff[IDX_W-1:0]];
         rd_count_ff <= count_mem[idx_ff[IDX_W-1:0]];
      end
      if (cmd.append) begin
         value_mem[used_ff[IDX_W-1:0]] <= sample_ff;
         count_mem[used_ff[IDX_W-1:0]] <= hmc_pkg::COUNT_W'(1);
      end else if (cmd.cnt_upd) begin
         count_mem[idx_ff[IDX_W-1:0]] <= cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         dcnt_ff      <= '0;
         scnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.append)  used_ff <= used_ff + 1'b1;
         if (cmd.set_ovf) ovf_ff  <= 1'b1;
         if (cmd.idx_clr)      idx_ff <= '0;
         else if (cmd.idx_inc) idx_ff <= idx_ff + 1'b1;
         if (cmd.div_mean || cmd.div_var) dcnt_ff <= DCNT_W'(hmc_pkg::DVD_W);
         else if (cmd.div_step)           dcnt_ff <= dcnt_ff - 1'b1;
         if (cmd.sqrt_start)     scnt_ff <= SCNT_W'(hmc_pkg::ROOT_W);
         else if (cmd.sqrt_step) scnt_ff <= scnt_ff - 1'b1;
         if (cmd.out_load)       out_valid_ff <= 1'b1;
         else if (rsp_tready)    out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= sample_in;
         sum_ff    <= '0;
      end else if (cmd.sum_acc) begin
         sum_ff <= sum_ff + hmc_pkg::SUM_W'(vc_prod);
      end

      // mean = floor(sum * 2^16 / n), saturating at 32 bits
      if (cmd.div_mean) begin
         quo_ff <= {sum_ff, 16'h0000};
         dvs_ff <= hmc_pkg::DVS_W'(n_eff);
         rem_ff <= '0;
      end else if (cmd.div_var) begin
         // floor(floor(v/n)/n) == floor(v/(n*n))
         quo_ff <= {16'h0000, var_ff};
         dvs_ff <= n_sq;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? rem_sub : rem_sh;
         quo_ff <= {quo_ff[hmc_pkg::DVD_W-2:0], div_ge};
      end

      if (cmd.mean_load) begin
         mean_ff <= (|quo_ff[hmc_pkg::DVD_W-1:32]) ? '1 : quo_ff[31:0];
         var_ff  <= '0;
      end else if (cmd.var_add) begin
         var_ff <= ((|term[67:64]) || var_sum[hmc_pkg::SUM_W]) ? '1
                                                             : var_sum[hmc_pkg::SUM_W-1:0];
      end

      if (cmd.sq_calc) sq_ff  <= dev * dev;
      if (cmd.mul_lo)  plo_ff <= sq_ff[23:0] * rd_count_ff;
      if (cmd.mul_hi)  phi_ff <= sq_ff[47:24] * rd_count_ff;

      if (cmd.sqrt_start) begin
         x_ff    <= quo_ff[hmc_pkg::SUM_W-1:0];
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         srem_ff <= sq_ge ? srem_sh - trial : srem_sh;
         root_ff <= {root_ff[hmc_pkg::ROOT_W-2:0], sq_ge};
         x_ff    <= {x_ff[hmc_pkg::SUM_W-3:0], 2'b00};
      end

      if (cmd.half_calc) begin
         half_ff <= (|half_prod[47:36]) ? '1 : half_prod[35:4];
      end

      if (cmd.out_load) begin
         out_data_ff <= {5'b00000, ovf_ff, up_bound, lo_bound, half_ff, mean_ff};
      end
   end

endmodule

// ----- rtl/core/hmc_checker.sv -----
// hmc_checker: port-level checks of histogram_mean_confidence, bound to the top.
// Watches the result stream and the register port.
// Depends on hmc_pkg for widths.
module hmc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [hmc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                               csr_pready
);

   a_reset_clears_rsp : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_upper : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[129:97] ==
         ({1'b0, rsp_tdata[31:0]} + {1'b0, rsp_tdata[63:32]}))
      else $error("upper bound is not mean plus half width");

   a_lower : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[96:64] ==
         ({1'b0, rsp_tdata[31:0]} - {1'b0, rsp_tdata[63:32]}))
      else $error("lower bound is not mean minus half width");

   a_pready : assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port stalled");

endmodule

bind histogram_mean_confidence hmc_checker u_hmc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
